### hdl/ucfd_pkg.sv
// Shared types and constants for the serial command frame decoder.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package ucfd_pkg;

  // Payload store depth and the widths that follow from it
  localparam int MAX_PAYLOAD = 14;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);

  // Result queue between parser and output stage
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int RESULT_W    = 66;
  localparam int OUT_TDATA_W = 72;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HEAD_ONE  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HEAD_TWO  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TAIL_ONE  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TAIL_TWO  = 3'd4;

  localparam logic [7:0] HEAD_ONE_RESET = 8'hA5;
  localparam logic [7:0] HEAD_TWO_RESET = 8'h5A;
  localparam logic [7:0] TAIL_ONE_RESET = 8'h0D;
  localparam logic [7:0] TAIL_TWO_RESET = 8'h0A;

  // Command frame contents
  localparam logic [7:0] SWEEP_BYTE_A = 8'hAA;
  localparam logic [7:0] SWEEP_BYTE_B = 8'hCC;
  localparam logic [7:0] AMP_MARKER   = 8'hA2;
  localparam logic [CNT_W-1:0] LEN_SWEEP    = CNT_W'(2);
  localparam logic [CNT_W-1:0] LEN_FREQ     = CNT_W'(4);
  localparam logic [CNT_W-1:0] LEN_FREQ_AMP = CNT_W'(9);

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_HEAD1 = 2'd1,
    PH_FRAME = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CMD_SWEEP    = 2'd0,
    CMD_FREQ     = 2'd1,
    CMD_FREQ_AMP = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] frequency_word;
    logic [31:0] amplitude_word;
  } result_t;

  // A decoded command offered on one side of the queue
  typedef struct packed {
    logic    valid;
    result_t data;
  } q_entry_t;

endpackage

### hdl/ucfd_front.sv
// Front end: configuration registers, header/tail parser, payload store and
// frame decode. Depends on ucfd_pkg; pushes decoded commands into ucfd_fifo.
`timescale 1ns / 1ps

module ucfd_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ucfd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ucfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,
  input  logic                            q_full,
  output ucfd_pkg::q_entry_t              q_push
);
  import ucfd_pkg::*;

  logic       enable;
  logic [7:0] head_byte_one, head_byte_two, tail_byte_one, tail_byte_two;

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] payload_count, payload_count_next;
  logic             tail_one_seen, tail_one_seen_next;
  logic [7:0]       payload_store [MAX_PAYLOAD];

  logic accept, store_we, frame_done, room;
  logic match_sweep, match_freq, match_amp;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign room     = payload_count < CNT_W'(MAX_PAYLOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      head_byte_one <= HEAD_ONE_RESET;
      head_byte_two <= HEAD_TWO_RESET;
      tail_byte_one <= TAIL_ONE_RESET;
      tail_byte_two <= TAIL_TWO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ENABLE:   enable        <= cfg_wdata[0];
        REG_HEAD_ONE: head_byte_one <= cfg_wdata;
        REG_HEAD_TWO: head_byte_two <= cfg_wdata;
        REG_TAIL_ONE: tail_byte_one <= cfg_wdata;
        REG_TAIL_TWO: tail_byte_two <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HEAD1: phase_next = (s_tdata == head_byte_two) ? PH_FRAME : PH_HUNT;
      PH_FRAME: begin
        if (tail_one_seen) begin
          phase_next = (s_tdata == tail_byte_two) ? PH_HUNT : PH_FRAME;
        end else if (s_tdata == tail_byte_one || room) begin
          phase_next = PH_FRAME;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      default: phase_next = (s_tdata == head_byte_one) ? PH_HEAD1 : PH_HUNT;
    endcase
  end

  // Per-byte actions
  always_comb begin
    payload_count_next = payload_count;
    tail_one_seen_next = tail_one_seen;
    store_we           = 1'b0;
    frame_done         = 1'b0;
    unique case (phase)
      PH_HEAD1: begin
        if (s_tdata == head_byte_two) begin
          payload_count_next = '0;
          tail_one_seen_next = 1'b0;
        end
      end
      PH_FRAME: begin
        if (tail_one_seen) begin
          // A tail-one byte not followed by tail-two is lost with this byte.
          tail_one_seen_next = 1'b0;
          if (s_tdata == tail_byte_two) begin
            frame_done         = 1'b1;
            payload_count_next = '0;
          end
        end else if (s_tdata == tail_byte_one) begin
          tail_one_seen_next = 1'b1;
        end else if (room) begin
          store_we           = 1'b1;
          payload_count_next = payload_count + CNT_W'(1);
        end else begin
          payload_count_next = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      payload_count <= '0;
      tail_one_seen <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      payload_count <= payload_count_next;
      tail_one_seen <= tail_one_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_we) begin
      payload_store[payload_count[IDX_W-1:0]] <= s_tdata;
    end
  end

  // Decode only reads entries written in the current frame.
  assign match_sweep = payload_count == LEN_SWEEP && payload_store[0] == SWEEP_BYTE_A
                       && payload_store[1] == SWEEP_BYTE_B;
  assign match_freq  = payload_count == LEN_FREQ;
  assign match_amp   = payload_count == LEN_FREQ_AMP && payload_store[4] == AMP_MARKER;

  always_comb begin
    q_push.data.frequency_word = {payload_store[3], payload_store[2],
                                  payload_store[1], payload_store[0]};
    q_push.data.amplitude_word = '0;
    q_push.data.command        = CMD_FREQ;
    if (match_sweep) begin
      q_push.data.command        = CMD_SWEEP;
      q_push.data.frequency_word = '0;
    end else if (match_amp) begin
      q_push.data.command        = CMD_FREQ_AMP;
      q_push.data.amplitude_word = {payload_store[8], payload_store[7],
                                    payload_store[6], payload_store[5]};
    end
    q_push.valid = accept && frame_done && enable
                   && (match_sweep || match_freq || match_amp);
  end

endmodule

### hdl/ucfd_fifo.sv
// Short queue of decoded commands between the parser and the output stage.
// Depends on ucfd_pkg for the entry type and depth.
`timescale 1ns / 1ps

module ucfd_fifo (
  input  logic               clk,
  input  logic               rst,
  input  ucfd_pkg::q_entry_t push,
  output logic               full,
  output ucfd_pkg::q_entry_t head,
  input  logic               pop
);
  import ucfd_pkg::*;

  result_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.data  = entries[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

### hdl/ucfd_back.sv
// Output stage: registers one decoded command and presents it on the
// master stream. Depends on ucfd_pkg; draws entries from ucfd_fifo.
`timescale 1ns / 1ps

module ucfd_back (
  input  logic                                clk,
  input  logic                                rst,
  input  ucfd_pkg::q_entry_t                  head,
  output logic                                pop,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ucfd_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import ucfd_pkg::*;

  result_t result;

  // Load whenever the register is empty or its request is being taken.
  assign pop = head.valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= head.data;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - RESULT_W)'(0), result.amplitude_word,
                    result.frequency_word, result.command};

endmodule

### hdl/uart_command_frame_decoder.sv
// Serial command frame decoder, top level.
// Depends on ucfd_pkg, ucfd_front, ucfd_fifo and ucfd_back.
//
// Usage:
//   The slave stream takes one received byte per request. The parser hunts
//   for the two header bytes, collects up to MAX_PAYLOAD payload bytes and
//   decodes the frame when the two tail bytes arrive. A decoded command
//   leaves on the master stream as one request.
//   Configuration is written through cfg_we/cfg_addr/cfg_wdata while the
//   block is idle; addresses past the tail-two register are ignored.
//   Throughput is one byte per cycle while the queue is not full. A decoded
//   command is first written into the queue and is then loaded into the
//   output register, which raises m_tvalid.
//   When the receiver stalls, decoded commands wait in the two-entry queue
//   and the output register; s_tready drops only once the queue is full.
//   Reset (rst, synchronous) clears the parser to header hunting, empties
//   the queue and output stage, disables decoding and restores the default
//   header and tail bytes.
`timescale 1ns / 1ps

module uart_command_frame_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ucfd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ucfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata: [7:0] rx_data
  input  logic [ucfd_pkg::IN_TDATA_W-1:0] s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: [1:0] command, [33:2] frequency_word, [65:34] amplitude_word,
  // [71:66] zero
  output logic [ucfd_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import ucfd_pkg::*;

  q_entry_t q_push, q_head;
  logic     q_full, q_pop;

  ucfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  ucfd_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .full (q_full),
    .head (q_head),
    .pop  (q_pop)
  );

  ucfd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // A decoded command must never be offered to a full queue.
  assert property (@(posedge clk) disable iff (rst) q_push.valid |-> !q_full)
    else $error("command pushed into full queue");

  // Sweep start carries no frequency or amplitude.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == CMD_SWEEP |-> m_tdata[65:2] == '0)
    else $error("sweep start with nonzero words");

  // Plain frequency commands carry no amplitude.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == CMD_FREQ |-> m_tdata[65:34] == '0)
    else $error("frequency command with nonzero amplitude");

  // Nothing can be pending in the cycle after reset.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

### verif/tb_uart_command_frame_decoder.sv
// Self-checking testbench for the serial command frame decoder.
// Depends on ucfd_pkg and uart_command_frame_decoder; byte stream in, command stream out.
`timescale 1ns / 1ps

module tb_uart_command_frame_decoder;
  import ucfd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_GAP       = 19;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  // s_tdata: [7:0] rx_data
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  // m_tdata: [1:0] command, [33:2] frequency_word, [65:34] amplitude_word, [71:66] zero
  logic [OUT_TDATA_W-1:0] m_tdata;

  uart_command_frame_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Shadow copy of the configuration registers
  logic       en_q       = 1'b0;
  logic [7:0] head_one_q = HEAD_ONE_RESET;
  logic [7:0] head_two_q = HEAD_TWO_RESET;
  logic [7:0] tail_one_q = TAIL_ONE_RESET;
  logic [7:0] tail_two_q = TAIL_TWO_RESET;

  // Shadow copy of the parser
  phase_t     parse_phase      = PH_HUNT;
  int         stored_count     = 0;
  bit         tail_one_pending = 1'b0;
  logic [7:0] payload_mem [MAX_PAYLOAD];

  logic [7:0] byte_queue[$];
  result_t    command_queue[$];
  logic [7:0] frame_buf[$];
  int         queued_total = 0;
  int         mismatches   = 0;
  int         cycle_count  = 0;

  int tx_wait = 0;
  int tx_run  = 0;
  bit tx_calm = 1'b0;
  bit tx_hold;
  int rx_wait = 0;
  int rx_run  = 0;
  bit rx_calm = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] le_word(int first);
    return {payload_mem[first+3], payload_mem[first+2], payload_mem[first+1], payload_mem[first]};
  endfunction

  // Decodes the frame held in the shadow store; queues a command if it is one and decoding is enabled.
  task automatic decode_frame();
    result_t cmd;
    bit      hit;
    cmd = '0;
    hit = 1'b1;
    if (stored_count == 2 && payload_mem[0] == SWEEP_BYTE_A && payload_mem[1] == SWEEP_BYTE_B) begin
      cmd.command = CMD_SWEEP;
    end else if (stored_count == 4) begin
      cmd.command        = CMD_FREQ;
      cmd.frequency_word = le_word(0);
    end else if (stored_count == 9 && payload_mem[4] == AMP_MARKER) begin
      cmd.command        = CMD_FREQ_AMP;
      cmd.frequency_word = le_word(0);
      cmd.amplitude_word = le_word(5);
    end else begin
      hit = 1'b0;
    end
    if (en_q && hit) command_queue.push_back(cmd);
  endtask

  task automatic parse_byte(logic [7:0] b);
    if (parse_phase != PH_FRAME) begin
      if (parse_phase != PH_HEAD1) begin
        parse_phase = (b == head_one_q) ? PH_HEAD1 : PH_HUNT;
      end else if (b == head_two_q) begin
        parse_phase      = PH_FRAME;
        stored_count     = 0;
        tail_one_pending = 1'b0;
      end else begin
        parse_phase = PH_HUNT;
      end
    end else if (tail_one_pending) begin
      // The byte after tail one is consumed whether or not it completes the frame.
      tail_one_pending = 1'b0;
      if (b == tail_two_q) begin
        decode_frame();
        parse_phase  = PH_HUNT;
        stored_count = 0;
      end
    end else if (b == tail_one_q) begin
      tail_one_pending = 1'b1;
    end else if (stored_count < MAX_PAYLOAD) begin
      payload_mem[stored_count] = b;
      stored_count++;
    end else begin
      stored_count = 0;
      parse_phase  = PH_HUNT;
    end
  endtask

  function automatic int draw_gap(inout int run_left, inout bit calm);
    // Gaps come in stretches: some stretches have none at all.
    if (run_left == 0) begin
      run_left = $urandom_range(8, 60);
      calm     = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic check_result();
    result_t want;
    if (command_queue.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected command: cmd %0d freq %h amp %h",
                 m_tdata[1:0], m_tdata[33:2], m_tdata[65:34]);
    end else begin
      want = command_queue.pop_front();
      if (m_tdata[1:0] !== want.command || m_tdata[33:2] !== want.frequency_word ||
          m_tdata[65:34] !== want.amplitude_word) begin
        mismatches++;
        if (mismatches <= 10)
          $display("command mismatch: expected cmd %0d freq %h amp %h, got cmd %0d freq %h amp %h",
                   want.command, want.frequency_word, want.amplitude_word,
                   m_tdata[1:0], m_tdata[33:2], m_tdata[65:34]);
      end
    end
  endtask

  // Byte driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_wait = 0;
    end else begin
      tx_hold = s_tvalid && !s_tready;
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata);
        tx_wait = draw_gap(tx_run, tx_calm);
      end
      if (!tx_hold) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_tvalid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          s_tdata  <= byte_queue.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Command monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_result();
        rx_wait = draw_gap(rx_run, rx_calm);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      m_tready <= (rx_wait == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_ENABLE:   en_q       = val[0];
      REG_HEAD_ONE: head_one_q = val;
      REG_HEAD_TWO: head_two_q = val;
      REG_TAIL_ONE: tail_one_q = val;
      REG_TAIL_TWO: tail_two_q = val;
      default: ;
    endcase
  endtask

  // Writes every register, plus one random index past the last, which must be ignored.
  task automatic set_regs(logic en, logic [7:0] h1, logic [7:0] h2, logic [7:0] t1,
                          logic [7:0] t2);
    cfg_write(REG_ENABLE, {7'd0, en});
    cfg_write(REG_HEAD_ONE, h1);
    cfg_write(REG_HEAD_TWO, h2);
    cfg_write(REG_TAIL_ONE, t1);
    cfg_write(REG_TAIL_TWO, t2);
    cfg_write(CFG_ADDR_W'(REG_TAIL_TWO + 1 + $urandom_range(0, 2)), 8'($urandom_range(0, 255)));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every byte is taken and every command has come back.
  task automatic wait_quiet();
    do @(negedge clk);
    while (byte_queue.size() != 0 || s_tvalid || command_queue.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_byte(logic [7:0] b);
    byte_queue.push_back(b);
    queued_total++;
  endtask

  task automatic push_frame();
    push_byte(head_one_q);
    push_byte(head_two_q);
    foreach (frame_buf[i]) push_byte(frame_buf[i]);
    push_byte(tail_one_q);
    push_byte(tail_two_q);
  endtask

  // A payload byte that cannot be taken for the start of the tail.
  function automatic logic [7:0] pay_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == tail_one_q);
    return b;
  endfunction

  task automatic fill_payload(int n);
    repeat (n) frame_buf.push_back(pay_byte());
  endtask

  task automatic gen_random(int n);
    int         goal;
    int         kind;
    int         pos;
    logic [7:0] b;
    goal = queued_total + n;
    while (queued_total < goal) begin
      kind = $urandom_range(0, 99);
      frame_buf.delete();
      if (kind < 18) begin
        frame_buf = '{SWEEP_BYTE_A, SWEEP_BYTE_B};
        push_frame();
      end else if (kind < 38) begin
        fill_payload(4);
        push_frame();
      end else if (kind < 58) begin
        fill_payload(4);
        frame_buf.push_back(AMP_MARKER);
        fill_payload(4);
        push_frame();
      end else if (kind < 64) begin
        // Nine bytes with a random marker, mostly an unknown frame.
        fill_payload(9);
        push_frame();
      end else if (kind < 72) begin
        // Any length, up to past the store depth so that overflow aborts.
        fill_payload($urandom_range(0, MAX_PAYLOAD + 2));
        push_frame();
      end else if (kind < 80) begin
        // A lone tail-one byte swallows the byte after it; the frame goes on.
        fill_payload(4);
        if ($urandom_range(0, 1)) begin
          frame_buf.push_back(AMP_MARKER);
          fill_payload(4);
        end
        pos = $urandom_range(0, frame_buf.size());
        do b = 8'($urandom_range(0, 255));
        while (b == tail_two_q);
        frame_buf.insert(pos, b);
        frame_buf.insert(pos, tail_one_q);
        push_frame();
      end else if (kind < 86) begin
        if ($urandom_range(0, 1)) frame_buf = '{SWEEP_BYTE_A, pay_byte()};
        else frame_buf = '{pay_byte(), SWEEP_BYTE_B};
        push_frame();
      end else if (kind < 93) begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
      end else begin
        push_byte(head_one_q);
        if ($urandom_range(0, 1)) push_byte(head_one_q);
        else push_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    logic [7:0] rep_head;
    logic [7:0] rep_tail;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_regs(1'b1, HEAD_ONE_RESET, HEAD_TWO_RESET, TAIL_ONE_RESET, TAIL_TWO_RESET);
    // A second header-one byte breaks the header rather than restarting it.
    push_byte(head_one_q);
    push_byte(head_one_q);
    push_byte(head_two_q);
    frame_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    push_frame();
    frame_buf = '{8'h00, 8'h00, 8'h00, 8'h00, AMP_MARKER, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    push_frame();
    gen_random(250);
    // The sender holds off here until every command has been returned.
    wait_quiet();
    gen_random(250);
    wait_quiet();

    // Decoding disabled: the parse goes on but no command leaves.
    set_regs(1'b0, HEAD_ONE_RESET, HEAD_TWO_RESET, TAIL_ONE_RESET, TAIL_TWO_RESET);
    gen_random(150);
    wait_quiet();

    set_regs(1'b1, 8'h00, 8'hFF, 8'hFF, 8'h00);
    gen_random(300);
    wait_quiet();

    set_regs(1'b1, 8'hFF, 8'h00, 8'h00, 8'hFF);
    gen_random(300);
    wait_quiet();

    set_regs(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    gen_random(300);
    wait_quiet();

    // Equal header bytes and equal tail bytes.
    rep_head = 8'($urandom_range(0, 255));
    rep_tail = 8'($urandom_range(0, 255));
    set_regs(1'b1, rep_head, rep_head, rep_tail, rep_tail);
    gen_random(200);
    wait_quiet();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### uart_command_frame_decoder.f
hdl/ucfd_pkg.sv
hdl/ucfd_front.sv
hdl/ucfd_fifo.sv
hdl/ucfd_back.sv
hdl/uart_command_frame_decoder.sv
verif/tb_uart_command_frame_decoder.sv
